FILE: rtl/core/can_rxq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_rxq_pkg
// Shared types and constants for the receive object decoder and frame ring.
// ----------------------------------------------------------------------------
package can_rxq_pkg;

    localparam int BASE_W  = 11;
    localparam int EXT_W   = 18;
    localparam int IDENT_W = BASE_W + EXT_W;
    localparam int LEN_W   = 4;
    localparam int STAMP_W = 32;
    localparam int DATA_W  = 64;
    localparam int CNT_W   = 32;
    localparam int HELD_W  = 5;
    localparam int BYTES   = DATA_W / 8;

    localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic               extended;
        logic               remote;
        logic [LEN_W-1:0]   length;
        logic [STAMP_W-1:0] stamp;
        logic [DATA_W-1:0]  payload;
    } frame_t;

endpackage

FILE: rtl/core/can_rxq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_rxq_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module can_rxq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/can_rxq_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_rxq_decode
// Turns a raw receive object into a frame: identifier swap, length clamp and
// masking of unused data bytes.
// ----------------------------------------------------------------------------
module can_rxq_decode
    import can_rxq_pkg::*;
(
    input  logic [31:0]        obj_id_word,
    input  logic [31:0]        obj_ctrl_word,
    input  logic [STAMP_W-1:0] obj_stamp,
    input  logic [DATA_W-1:0]  obj_payload,
    output frame_t             frame
);

    logic [LEN_W-1:0] code;
    logic [LEN_W-1:0] len;
    logic             ext;
    logic             rem;

    assign code = obj_ctrl_word[LEN_W-1:0];
    assign ext  = obj_ctrl_word[4];
    assign rem  = obj_ctrl_word[5];
    assign len  = (code > MAX_LEN) ? MAX_LEN : code;

    always_comb
    begin
        frame          = '0;
        frame.extended = ext;
        frame.remote   = rem;
        frame.length   = len;
        frame.stamp    = obj_stamp;
        if (ext)
        begin
            frame.ident = {obj_id_word[BASE_W-1:0], obj_id_word[BASE_W+EXT_W-1:BASE_W]};
        end
        else
        begin
            frame.ident = {{EXT_W{1'b0}}, obj_id_word[BASE_W-1:0]};
        end
        // keep only bytes below the length, none for remote frames
        for (int i = 0; i < BYTES; i++)
        begin
            if (!rem && (LEN_W'(i) < len))
            begin
                frame.payload[i*8 +: 8] = obj_payload[i*8 +: 8];
            end
        end
    end

endmodule

FILE: rtl/core/can_rx_object_decode_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_rx_object_decode_queue_top
// Receive object decoder feeding a frame ring held in one synchronous memory.
//
// Input channel (in_valid / in_stall) carries one item: a push of a raw
// receive object, a pop of the oldest frame, or a clear of ring and counters.
// Every item gives exactly one result item on the output channel
// (out_valid / out_stall) in the cycle after it is accepted.
// Unstalled throughput is one item per cycle: a push is one memory write,
// a pop is one memory read whose registered data feeds the result directly.
// The ring keeps one slot empty and so holds up to RING_DEPTH-1 frames.
// While a result waits under out_stall, in_stall is raised and ring state and
// counters hold, so the waiting result stays unchanged.
// Reset empties the ring and zeroes both counters at once; memory contents
// are not cleared, only slots between the read and write indices are read.
// ----------------------------------------------------------------------------
module can_rx_object_decode_queue_top
    import can_rxq_pkg::*;
#(
    parameter int RING_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [31:0]        obj_id_word,
    input  logic [31:0]        obj_ctrl_word,
    input  logic [STAMP_W-1:0] obj_stamp,
    input  logic [DATA_W-1:0]  obj_payload,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               frame_valid,
    output logic [IDENT_W-1:0] frame_ident,
    output logic               frame_extended,
    output logic               frame_remote,
    output logic [LEN_W-1:0]   frame_length,
    output logic [DATA_W-1:0]  frame_payload,
    output logic [STAMP_W-1:0] frame_stamp,
    output logic               push_dropped,
    output logic [CNT_W-1:0]   overflow_total,
    output logic [CNT_W-1:0]   received_total,
    output logic [HELD_W-1:0]  entries_held
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int HW = (AW + 1 > HELD_W) ? AW + 1 : HELD_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

    logic             accept;
    frame_t           dec_frame;
    frame_t           rd_frame;

    logic [AW-1:0]    wr_idx_reg, wr_idx_next;
    logic [AW-1:0]    rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] ovf_cnt_reg, ovf_cnt_next;
    logic [CNT_W-1:0] rcv_cnt_reg, rcv_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             hit_reg, hit_next;
    logic             drop_reg, drop_next;

    logic [AW-1:0]    wr_idx_inc;
    logic [AW-1:0]    rd_idx_inc;
    logic             ring_full;
    logic             ring_empty;
    logic             mem_wr;
    logic             mem_rd;
    logic [HW-1:0]    held_full;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = out_valid_reg && out_stall;
    assign wr_idx_inc = (wr_idx_reg == LAST_SLOT) ? '0 : wr_idx_reg + 1'b1;
    assign rd_idx_inc = (rd_idx_reg == LAST_SLOT) ? '0 : rd_idx_reg + 1'b1;
    assign ring_full  = (wr_idx_inc == rd_idx_reg);
    assign ring_empty = (wr_idx_reg == rd_idx_reg);

    can_rxq_decode u_decode (
        .obj_id_word   (obj_id_word),
        .obj_ctrl_word (obj_ctrl_word),
        .obj_stamp     (obj_stamp),
        .obj_payload   (obj_payload),
        .frame         (dec_frame)
    );

    can_rxq_ram #(
        .WIDTH ($bits(frame_t)),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (wr_idx_reg),
        .wr_data (dec_frame),
        .rd_en   (mem_rd),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_frame)
    );

    always_comb
    begin
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        ovf_cnt_next   = ovf_cnt_reg;
        rcv_cnt_next   = rcv_cnt_reg;
        hit_next       = hit_reg;
        drop_next      = drop_reg;
        mem_wr         = 1'b0;
        mem_rd         = 1'b0;
        out_valid_next = accept || (out_valid_reg && out_stall);
        if (accept)
        begin
            hit_next  = 1'b0;
            drop_next = 1'b0;
            unique case (kind)
                KIND_PUSH:
                begin
                    rcv_cnt_next = (rcv_cnt_reg == '1) ? rcv_cnt_reg : rcv_cnt_reg + 1'b1;
                    if (ring_full)
                    begin
                        drop_next    = 1'b1;
                        ovf_cnt_next = (ovf_cnt_reg == '1) ? ovf_cnt_reg
                                                           : ovf_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        mem_wr      = 1'b1;
                        wr_idx_next = wr_idx_inc;
                    end
                end
                KIND_POP:
                begin
                    if (!ring_empty)
                    begin
                        hit_next    = 1'b1;
                        mem_rd      = 1'b1;
                        rd_idx_next = rd_idx_inc;
                    end
                end
                KIND_CLEAR:
                begin
                    wr_idx_next  = '0;
                    rd_idx_next  = '0;
                    ovf_cnt_next = '0;
                    rcv_cnt_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            ovf_cnt_reg   <= '0;
            rcv_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            drop_reg      <= 1'b0;
        end
        else
        begin
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            ovf_cnt_reg   <= ovf_cnt_next;
            rcv_cnt_reg   <= rcv_cnt_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            drop_reg      <= drop_next;
        end
    end

    // fill level from the indices, which hold while a result waits
    always_comb
    begin
        if (wr_idx_reg >= rd_idx_reg)
        begin
            held_full = HW'(wr_idx_reg) - HW'(rd_idx_reg);
        end
        else
        begin
            held_full = HW'(wr_idx_reg) + HW'(RING_DEPTH) - HW'(rd_idx_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_valid    = hit_reg;
    assign frame_ident    = hit_reg ? rd_frame.ident    : '0;
    assign frame_extended = hit_reg ? rd_frame.extended : 1'b0;
    assign frame_remote   = hit_reg ? rd_frame.remote   : 1'b0;
    assign frame_length   = hit_reg ? rd_frame.length   : '0;
    assign frame_payload  = hit_reg ? rd_frame.payload  : '0;
    assign frame_stamp    = hit_reg ? rd_frame.stamp    : '0;
    assign push_dropped   = drop_reg;
    assign overflow_total = ovf_cnt_reg;
    assign received_total = rcv_cnt_reg;
    assign entries_held   = held_full[HELD_W-1:0];

    // assertions
    a_stall_only_when_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with no result pending");

    a_drop_not_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && drop_reg))
        else $error("result marked both popped and dropped");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_CLEAR) |=>
            (ovf_cnt_reg == '0 && rcv_cnt_reg == '0 && wr_idx_reg == rd_idx_reg))
        else $error("clear left ring or counters non-zero");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(wr_idx_reg) < RING_DEPTH) && (int'(rd_idx_reg) < RING_DEPTH))
        else $error("ring index beyond depth");

    a_pop_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_POP && !ring_empty) |=> (out_valid_reg && hit_reg))
        else $error("pop of non-empty ring gave no frame");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the receive object decoder and frame ring. A short
// table of directed items covers the field extremes, every kind, clamping,
// remote frames, ignored bits, empty pops and clear. Random traffic follows,
// run in bursts that fill the ring to overflow, drain it, or mix both. Every
// accepted item is run through a local decoder and ring copy, and each result
// item is compared field by field with the oldest expected one. Sender and
// receiver idle at random, in turn, then not at all.
// ----------------------------------------------------------------------------
module tb
    import can_rxq_pkg::*;
();

    localparam int RING_SLOTS  = 32;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 450;
    localparam int DIR_ROWS    = 25;
    localparam int REPORT_MAX  = 10;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    typedef struct packed {
        logic               valid;
        logic [IDENT_W-1:0] ident;
        logic               extended;
        logic               remote;
        logic [LEN_W-1:0]   length;
        logic [DATA_W-1:0]  payload;
        logic [STAMP_W-1:0] stamp;
        logic               dropped;
        logic [CNT_W-1:0]   overflows;
        logic [CNT_W-1:0]   received;
        logic [HELD_W-1:0]  held;
    } rx_result_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] id_word;
        logic [31:0] ctrl_word;
        logic [31:0] stamp;
        logic [63:0] payload;
        logic        typed;
        rx_result_t  res;
    } dir_row_t;

    function automatic rx_result_t only_counts(input logic [CNT_W-1:0] ovf,
                                               input logic [CNT_W-1:0] rcv,
                                               input logic [HELD_W-1:0] held);
        rx_result_t r;
        r = '0;
        r.overflows = ovf;
        r.received  = rcv;
        r.held      = held;
        return r;
    endfunction

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{KIND_POP, 32'h0, 32'h0, 32'h0, 64'h0, 1'b1, only_counts(32'd0, 32'd0, 5'd0)},
        '{KIND_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
          64'hffff_ffff_ffff_ffff, 1'b1, only_counts(32'd0, 32'd0, 5'd0)},
        '{KIND_PUSH, 32'hffff_ffff, 32'h0000_0008, 32'hffff_ffff,
          64'hffff_ffff_ffff_ffff, 1'b1, only_counts(32'd0, 32'd1, 5'd1)},
        '{KIND_PUSH, 32'hffff_ffff, 32'hffff_ffdf, 32'h0,
          64'ha5a5_5a5a_0f0f_f0f0, 1'b1, only_counts(32'd0, 32'd2, 5'd2)},
        '{KIND_PUSH, 32'h0, 32'hffff_ffff, 32'h1234_5678,
          64'hffff_ffff_ffff_ffff, 1'b1, only_counts(32'd0, 32'd3, 5'd3)},
        '{KIND_PUSH, 32'he000_0000, 32'hffff_ffc0, 32'h1,
          64'hffff_ffff_ffff_ffff, 1'b1, only_counts(32'd0, 32'd4, 5'd4)},
        '{KIND_PUSH, 32'h0000_0555, 32'h3, 32'h100, 64'h1122_3344_5566_7788, 1'b0, '0},
        '{KIND_PUSH, 32'h1234_5678, 32'h17, 32'h8000_0000, 64'h8877_6655_4433_2211,
          1'b0, '0},
        '{KIND_PUSH, 32'h2aa, 32'hc, 32'h5555_aaaa, 64'hdead_beef_cafe_f00d, 1'b0, '0},
        '{KIND_PUSH, 32'h3ff, 32'h22, 32'haaaa_5555, 64'h0123_4567_89ab_cdef, 1'b0, '0},
        '{KIND_POP, 32'h0, 32'h0, 32'h0, 64'h0, 1'b1,
          '{1'b1, 29'h7ff, 1'b0, 1'b0, 4'd8, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff,
            1'b0, 32'd0, 32'd8, 5'd7}},
        '{KIND_POP, 32'h0, 32'h0, 32'h0, 64'h0, 1'b0, '0},
        '{KIND_POP, 32'h0, 32'h0, 32'h0, 64'h0, 1'b0, '0},
        '{KIND_POP, 32'h0, 32'h0, 32'h0, 64'h0, 1'b0, '0},
        '{KIND_POP, 32'h0, 32'h0, 32'h0, 64'h0, 1'b0, '0},
        '{KIND_POP, 32'h0, 32'h0, 32'h0, 64'h0, 1'b0, '0},
        '{KIND_POP, 32'h0, 32'h0, 32'h0, 64'h0, 1'b0, '0},
        '{KIND_POP, 32'h0, 32'h0, 32'h0, 64'h0, 1'b0, '0},
        '{KIND_POP, 32'h0, 32'h0, 32'h0, 64'h0, 1'b1, only_counts(32'd0, 32'd8, 5'd0)},
        '{KIND_UNUSED, 32'h5a5a_a5a5, 32'h1f, 32'h0f0f_0f0f, 64'h0f0f_f0f0_a5a5_5a5a,
          1'b1, only_counts(32'd0, 32'd8, 5'd0)},
        '{KIND_PUSH, 32'h1555_5555, 32'h19, 32'h7fff_ffff, 64'hfedc_ba98_7654_3210,
          1'b0, '0},
        '{KIND_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
          64'hffff_ffff_ffff_ffff, 1'b1, only_counts(32'd0, 32'd0, 5'd0)},
        '{KIND_POP, 32'h0, 32'h0, 32'h0, 64'h0, 1'b1, only_counts(32'd0, 32'd0, 5'd0)},
        '{KIND_PUSH, 32'h0000_0001, 32'h1, 32'h0, 64'hffff_ffff_ffff_ffff, 1'b0, '0},
        '{KIND_POP, 32'h0, 32'h0, 32'h0, 64'h0, 1'b0, '0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         kind = KIND_PUSH;
    logic [31:0]        obj_id_word = '0;
    logic [31:0]        obj_ctrl_word = '0;
    logic [STAMP_W-1:0] obj_stamp = '0;
    logic [DATA_W-1:0]  obj_payload = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               frame_valid;
    logic [IDENT_W-1:0] frame_ident;
    logic               frame_extended;
    logic               frame_remote;
    logic [LEN_W-1:0]   frame_length;
    logic [DATA_W-1:0]  frame_payload;
    logic [STAMP_W-1:0] frame_stamp;
    logic               push_dropped;
    logic [CNT_W-1:0]   overflow_total;
    logic [CNT_W-1:0]   received_total;
    logic [HELD_W-1:0]  entries_held;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int cycle_count = 0;

    rx_result_t pending_results[$];

    // local copy of the frame ring
    frame_t         ring_frame [RING_SLOTS];
    int             ring_wr = 0;
    int             ring_rd = 0;
    logic [CNT_W-1:0] drop_count = '0;
    logic [CNT_W-1:0] rx_count = '0;

    can_rx_object_decode_queue_top #(
        .RING_DEPTH(RING_SLOTS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .obj_id_word(obj_id_word),
        .obj_ctrl_word(obj_ctrl_word),
        .obj_stamp(obj_stamp),
        .obj_payload(obj_payload),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .frame_valid(frame_valid),
        .frame_ident(frame_ident),
        .frame_extended(frame_extended),
        .frame_remote(frame_remote),
        .frame_length(frame_length),
        .frame_payload(frame_payload),
        .frame_stamp(frame_stamp),
        .push_dropped(push_dropped),
        .overflow_total(overflow_total),
        .received_total(received_total),
        .entries_held(entries_held)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic rx_result_t decode_and_queue(input logic [1:0] k,
                                                    input logic [31:0] idw,
                                                    input logic [31:0] ctl,
                                                    input logic [31:0] stamp,
                                                    input logic [63:0] pay);
        rx_result_t r;
        frame_t     f;
        int         nxt;
        r = '0;
        f = '0;
        case (k)
            KIND_PUSH:
            begin
                f.extended = ctl[4];
                f.remote   = ctl[5];
                f.length   = (ctl[3:0] > MAX_LEN) ? MAX_LEN : ctl[3:0];
                f.ident    = ctl[4] ? {idw[10:0], idw[28:11]} : {18'd0, idw[10:0]};
                f.stamp    = stamp;
                if (f.remote)
                    f.payload = '0;
                else if (f.length == MAX_LEN)
                    f.payload = pay;
                else
                    f.payload = pay & ((64'd1 << (8 * f.length)) - 64'd1);
                rx_count = bump(rx_count);
                nxt = (ring_wr + 1) % RING_SLOTS;
                if (nxt == ring_rd)
                begin
                    drop_count = bump(drop_count);
                    r.dropped = 1'b1;
                end
                else
                begin
                    ring_frame[ring_wr] = f;
                    ring_wr = nxt;
                end
            end
            KIND_POP:
            begin
                if (ring_rd != ring_wr)
                begin
                    f = ring_frame[ring_rd];
                    r.valid    = 1'b1;
                    r.ident    = f.ident;
                    r.extended = f.extended;
                    r.remote   = f.remote;
                    r.length   = f.length;
                    r.payload  = f.payload;
                    r.stamp    = f.stamp;
                    ring_rd = (ring_rd + 1) % RING_SLOTS;
                end
            end
            KIND_CLEAR:
            begin
                ring_wr = 0;
                ring_rd = 0;
                drop_count = '0;
                rx_count = '0;
            end
            default:
            begin
            end
        endcase
        r.overflows = drop_count;
        r.received  = rx_count;
        r.held      = HELD_W'((ring_wr + RING_SLOTS - ring_rd) % RING_SLOTS);
        return r;
    endfunction

    task automatic send_item(input logic [1:0] k, input logic [31:0] idw,
                             input logic [31:0] ctl, input logic [31:0] stamp,
                             input logic [63:0] pay, input logic typed,
                             input rx_result_t typed_res);
        int         gap;
        rx_result_t r;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        obj_id_word   <= idw;
        obj_ctrl_word <= ctl;
        obj_stamp     <= stamp;
        obj_payload   <= pay;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = decode_and_queue(k, idw, ctl, stamp, pay);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t mismatch on %s: expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        rx_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t result item with nothing pending", $time);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("frame_valid", want.valid, frame_valid);
                check_field("frame_ident", want.ident, frame_ident);
                check_field("frame_extended", want.extended, frame_extended);
                check_field("frame_remote", want.remote, frame_remote);
                check_field("frame_length", want.length, frame_length);
                check_field("frame_payload", want.payload, frame_payload);
                check_field("frame_stamp", want.stamp, frame_stamp);
                check_field("push_dropped", want.dropped, push_dropped);
                check_field("overflow_total", want.overflows, overflow_total);
                check_field("received_total", want.received, received_total);
                check_field("entries_held", want.held, entries_held);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL can_rx_object_decode_queue_top");
        $finish;
    end

    initial
    begin
        int          phase;
        int          n;
        int          row;
        int          mode;
        int          span;
        int          roll;
        logic [1:0]  k;
        logic [31:0] idw;
        logic [31:0] ctl;
        mode = MODE_MIXED;
        span = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 7;
                    recv_idle_pct <= 51;
                end
                1:
                begin
                    send_idle_pct = 51;
                    recv_idle_pct <= 7;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            if (phase == 0)
            begin
                for (row = 0; row < DIR_ROWS; row++)
                    send_item(DIR_TABLE[row].kind, DIR_TABLE[row].id_word,
                              DIR_TABLE[row].ctrl_word, DIR_TABLE[row].stamp,
                              DIR_TABLE[row].payload, DIR_TABLE[row].typed,
                              DIR_TABLE[row].res);
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(MODE_FILL, MODE_MIXED);
                    span = $urandom_range(10, 60);
                end
                span--;
                if (n == PHASE_ITEMS / 2)
                    wait_drained();
                roll = $urandom_range(0, 99);
                case (mode)
                    MODE_FILL:
                        k = (roll < 82) ? KIND_PUSH : (roll < 97) ? KIND_POP : KIND_UNUSED;
                    MODE_DRAIN:
                        k = (roll < 75) ? KIND_POP : (roll < 95) ? KIND_PUSH :
                            (roll < 98) ? KIND_UNUSED : KIND_CLEAR;
                    default:
                        k = (roll < 48) ? KIND_PUSH : (roll < 93) ? KIND_POP :
                            (roll < 98) ? KIND_UNUSED : KIND_CLEAR;
                endcase
                idw = $urandom;
                ctl = $urandom;
                ctl[5] = ($urandom_range(0, 3) == 0);
                send_item(k, idw, ctl, $urandom, {$urandom, $urandom}, 1'b0, '0);
            end
            wait_drained();
        end
        repeat (4) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS can_rx_object_decode_queue_top");
        else
            $display("FAIL can_rx_object_decode_queue_top");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/can_rxq_pkg.sv
rtl/core/can_rxq_ram.sv
rtl/core/can_rxq_decode.sv
rtl/core/can_rx_object_decode_queue_top.sv
test/tb.sv
